@@ hdl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_ATTR = '0;
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd15;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_BLANK,
    ST_DONE
  } state_t;

  // logical row + scroll offset, modulo ROWS
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

endpackage

@@ hdl/tcw_intf.sv @@
// ----------------------------------------------------------------------------
// tcw_in_if / tcw_out_if
// Valid/ready channels carrying console commands and results.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::ACT_W-1:0]  action;
  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::COL_W-1:0]  col;
  logic [tcw_pkg::ROW_W-1:0]  row;

  modport source (output valid, action, char_code, col, row, input ready);
  modport sink   (input valid, action, char_code, col, row, output ready);
endinterface

interface tcw_out_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::CHAR_W-1:0] read_char;
  logic [tcw_pkg::CHAR_W-1:0] read_attr;
  logic [tcw_pkg::COL_W-1:0]  cursor_col_out;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row_out;

  modport source (output valid, read_char, read_attr, cursor_col_out, cursor_row_out,
                  input ready);
  modport sink   (input valid, read_char, read_attr, cursor_col_out, cursor_row_out,
                  output ready);
endinterface

@@ hdl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tcw_cfg.sv @@
// ----------------------------------------------------------------------------
// tcw_cfg
// APB register slave holding the text attribute.
// ----------------------------------------------------------------------------
module tcw_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [tcw_pkg::CHAR_W-1:0]  text_attr
);
  import tcw_pkg::*;

  logic sel_attr;

  assign pready   = 1'b1;
  assign sel_attr = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && sel_attr) begin
      text_attr <= pwdata[CHAR_W-1:0];
    end
  end

  assign prdata = sel_attr ? {{(PDATA_W-CHAR_W){1'b0}}, text_attr} : '0;

endmodule

@@ hdl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor, scroll offset, cell writes, blank sweeps, reads.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tcw_pkg::CHAR_W-1:0] text_attr,
  tcw_in_if.sink                     in_ch,
  tcw_out_if.source                  out_ch,
  output logic                       mem_we,
  output logic [tcw_pkg::ADDR_W-1:0] mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
  output logic [tcw_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);
  import tcw_pkg::*;

  state_t             state, state_next;
  logic [COL_W-1:0]   cursor_col, cursor_col_next;
  logic [ROW_W-1:0]   cursor_row, cursor_row_next;
  logic [ROW_W-1:0]   top, top_next;
  logic [ADDR_W-1:0]  blank_addr, blank_addr_next;
  logic [ADDR_W-1:0]  blank_end, blank_end_next;
  logic [CHAR_W-1:0]  rd_char, rd_char_next;
  logic [CHAR_W-1:0]  rd_attr, rd_attr_next;
  logic               out_valid, out_valid_next;
  logic               out_load;
  logic [CHAR_W-1:0]  out_char, out_attr;
  logic [COL_W-1:0]   out_col;
  logic [ROW_W-1:0]   out_row;
  logic               accept;
  logic               is_nl;
  logic [COL_W:0]     col_inc;
  logic [ROW_W:0]     row_inc;
  logic [ROW_W:0]     new_row;
  logic               in_range;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_nl       = (in_ch.char_code == CH_NEWLINE);
  assign col_inc     = {1'b0, cursor_col} + (COL_W+1)'(1);
  assign row_inc     = {1'b0, cursor_row} + (ROW_W+1)'(1);
  assign in_range    = ({1'b0, in_ch.col} < (COL_W+1)'(COLS)) &&
                       ({1'b0, in_ch.row} < (ROW_W+1)'(ROWS));

  always_comb begin
    state_next      = state;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    top_next        = top;
    blank_addr_next = blank_addr;
    blank_end_next  = blank_end;
    rd_char_next    = rd_char;
    rd_attr_next    = rd_attr;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = blank_addr;
    mem_wdata       = {text_attr, CH_SPACE};
    mem_raddr       = cell_addr(phys_row(in_ch.row, top), in_ch.col);
    new_row         = {1'b0, cursor_row};

    case (state)
      ST_IDLE: begin
        if (accept) begin
          rd_char_next = '0;
          rd_attr_next = '0;
          state_next   = ST_DONE;
          case (action_t'(in_ch.action))
            ACT_PUT: begin
              if (is_nl) begin
                cursor_col_next = '0;
                new_row         = row_inc;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(phys_row(cursor_row, top), cursor_col);
                mem_wdata = {text_attr, in_ch.char_code};
                if (col_inc >= (COL_W+1)'(COLS)) begin
                  cursor_col_next = '0;
                  new_row         = row_inc;
                end else begin
                  cursor_col_next = col_inc[COL_W-1:0];
                end
              end
              if (new_row >= (ROW_W+1)'(ROWS)) begin
                // scroll: old top row becomes the new bottom row
                cursor_row_next = ROW_W'(ROWS - 1);
                top_next        = phys_row(ROW_W'(1), top);
                blank_addr_next = cell_addr(top, '0);
                blank_end_next  = cell_addr(top, COL_W'(COLS - 1));
                state_next      = ST_BLANK;
              end else begin
                cursor_row_next = new_row[ROW_W-1:0];
              end
            end
            ACT_SET: begin
              cursor_col_next = ({1'b0, in_ch.col} >= (COL_W+1)'(COLS)) ?
                                COL_W'(COLS - 1) : in_ch.col;
              cursor_row_next = ({1'b0, in_ch.row} >= (ROW_W+1)'(ROWS)) ?
                                ROW_W'(ROWS - 1) : in_ch.row;
            end
            ACT_CLEAR: begin
              cursor_col_next = '0;
              cursor_row_next = '0;
              top_next        = '0;
              blank_addr_next = '0;
              blank_end_next  = ADDR_W'(CELLS - 1);
              state_next      = ST_BLANK;
            end
            ACT_READ: begin
              if (in_range) begin
                state_next = ST_READ;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        rd_char_next = mem_rdata[CHAR_W-1:0];
        rd_attr_next = mem_rdata[CELL_W-1:CHAR_W];
        state_next   = ST_DONE;
      end
      ST_BLANK: begin
        mem_we          = 1'b1;
        blank_addr_next = blank_addr + ADDR_W'(1);
        if (blank_addr == blank_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      top        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      top        <= top_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    blank_addr <= blank_addr_next;
    blank_end  <= blank_end_next;
    rd_char    <= rd_char_next;
    rd_attr    <= rd_attr_next;
    if (out_load) begin
      out_char <= rd_char;
      out_attr <= rd_attr;
      out_col  <= cursor_col;
      out_row  <= cursor_row;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.read_char      = out_char;
  assign out_ch.read_attr      = out_attr;
  assign out_ch.cursor_col_out = out_col;
  assign out_ch.cursor_row_out = out_row;

endmodule

@@ hdl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text console: cell store, cursor and scroll via row offset.
// ----------------------------------------------------------------------------
// Path, accept to result valid: put char, set cursor and an out-of-range read go via
//   ST_DONE; read cell via ST_READ, ST_DONE; scrolling put and clear via ST_BLANK, ST_DONE.
// Flow: one transaction in flight; the next is taken after the result is loaded into
//   the output register, which waits while an earlier result is stalled on the result side.
// Reset: cursor home, scroll offset 0, attribute 15; cell store undefined until
//   written (clear the screen before reading).
module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  tcw_in_if.sink                      in_ch,
  tcw_out_if.source                   out_ch
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] text_attr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tcw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .text_attr (text_attr)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .text_attr (text_attr),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

@@ hdl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the console channels, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tcw_pkg::CHAR_W-1:0] read_char,
  input logic [tcw_pkg::CHAR_W-1:0] read_attr,
  input logic [tcw_pkg::COL_W-1:0]  cursor_col_out,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_row_out
);
  import tcw_pkg::*;

  // one transaction at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, cursor_col_out} < (COL_W+1)'(COLS) &&
                   {1'b0, cursor_row_out} < (ROW_W+1)'(ROWS)))
    else $error("cursor off screen");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid &&
      $stable({read_char, read_attr, cursor_col_out, cursor_row_out})))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .read_char      (out_ch.read_char),
  .read_attr      (out_ch.read_attr),
  .cursor_col_out (out_ch.cursor_col_out),
  .cursor_row_out (out_ch.cursor_row_out)
);
